@@ sv/wafb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Wavelet analysis filter bank package
// Shared widths, register indexes, controller states and the filter
// coefficient tables with their fixed-point reduction.
// ----------------------------------------------------------------------------
package wafb_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_BLOCK_DEF = 128;
  localparam int COEF_FRAC_DEF = 15;

  // Fixed structure of the filters.
  localparam int TAP_COUNT = 10;
  localparam int TAP_W     = 4;
  localparam int SET_COUNT = 5;
  localparam int BAND_LO   = 0;
  localparam int BAND_HI   = 1;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 18;
  localparam int BLEN_W     = 8;
  localparam int FSET_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register reset values.
  localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(64);
  localparam logic [FSET_W-1:0] FSET_RESET = FSET_W'(0);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_FILTER_SET   = 2'd1
  } cfg_reg_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Coefficients are kept with 30 fraction bits and reduced on lookup.
  localparam int Q30_W    = 32;
  localparam int Q30_FRAC = 30;

  localparam logic signed [Q30_W-1:0] QA = 32'sd747195449;
  localparam logic signed [Q30_W-1:0] QB = 32'sd94906266;
  localparam logic signed [Q30_W-1:0] QC = 32'sd12054676;
  localparam logic signed [Q30_W-1:0] QD = 32'sd816336241;
  localparam logic signed [Q30_W-1:0] QE = 32'sd630842971;
  localparam logic signed [Q30_W-1:0] QF = 32'sd251137819;
  localparam logic signed [Q30_W-1:0] QG = 32'sd122730666;
  localparam logic signed [Q30_W-1:0] QH = 32'sd94842993;
  localparam logic signed [Q30_W-1:0] QK = 32'sd37756886;
  localparam logic signed [Q30_W-1:0] QZ = 32'sd0;

  // Filter sets: Farras, first stage up, first stage down, dual up, dual down.
  localparam logic signed [Q30_W-1:0] COEF_Q30 [SET_COUNT][2][TAP_COUNT] = '{
    '{ '{QZ, QZ, -QB, QB, QA, QA, QB, -QB, QC, QC},
       '{-QC, QC, QB, QB, -QA, QA, -QB, -QB, QZ, QZ} },
    '{ '{QZ, -QB, QB, QA, QA, QB, -QB, QC, QC, QZ},
       '{QZ, -QC, QC, QB, QB, -QA, QA, -QB, -QB, QZ} },
    '{ '{QC, QC, -QB, QB, QA, QA, QB, -QB, QZ, QZ},
       '{QZ, QZ, -QB, -QB, QA, -QA, QB, QB, QC, -QC} },
    '{ '{QK, QZ, -QH, QF, QD, QE, QZ, -QG, QZ, QZ},
       '{QZ, QZ, -QG, QZ, QE, -QD, QF, QH, QZ, -QK} },
    '{ '{QZ, QZ, -QG, QZ, QE, QD, QF, -QH, QZ, QK},
       '{-QK, QZ, QH, QF, -QD, QE, QZ, -QG, QZ, QZ} }
  };

  // Reduce a coefficient to the given fraction bits, rounding the magnitude
  // half away from zero.
  function automatic logic signed [Q30_W-1:0] coef_round(
    input logic signed [Q30_W-1:0] q,
    input int                      frac
  );
    logic [Q30_W-1:0] mag;
    logic [Q30_W-1:0] rnd;
    int               sh;
    sh  = Q30_FRAC - frac;
    mag = q[Q30_W-1] ? $unsigned(-q) : $unsigned(q);
    rnd = (mag + (Q30_W'(1) << (sh - 1))) >> sh;
    return q[Q30_W-1] ? -$signed(rnd) : $signed(rnd);
  endfunction

endpackage
`default_nettype wire

@@ sv/wafb_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one signed input sample per request.
// ----------------------------------------------------------------------------
interface wafb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wafb_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ sv/wafb_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one lowpass/highpass pair per request.
// ----------------------------------------------------------------------------
interface wafb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wafb_pkg::OUT_W-1:0] low_band;
  logic signed [wafb_pkg::OUT_W-1:0] high_band;
  logic                              last;

  modport source (output valid, output low_band, output high_band, output last,
                  input ready);
  modport sink   (input valid, input low_band, input high_band, input last,
                  output ready);
endinterface
`default_nettype wire

@@ sv/wafb_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wafb_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wafb_pkg::CFG_IDX_W-1:0]      reg_index;
  logic [wafb_pkg::CFG_DATA_W-1:0]     wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

@@ sv/wavelet_analysis_filter_bank_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Wavelet analysis filter bank core
// Two-channel periodic 10-tap analysis filter bank with downsampling by two.
// ----------------------------------------------------------------------------
// Samples are collected one per cycle while the core is idle into a block
// buffer until the block length (clamped to 10..MAX_BLOCK) is reached. The
// sample that completes a block starts the filter pass, which holds the input
// off: one dual multiply-accumulate unit takes one tap per cycle for both
// bands, and a block of n samples yields ceil(n/2) lowpass/highpass pairs.
// Pairs leave through a two-entry output queue; a new pair is started only
// when the queue has room, so a stalled consumer stretches the pass. The last
// pair of the block arrives after input ready returns.
module wavelet_analysis_filter_bank_core #(
  parameter int MAX_BLOCK      = wafb_pkg::MAX_BLOCK_DEF,
  parameter int COEF_FRAC_BITS = wafb_pkg::COEF_FRAC_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  wafb_in_if.sink       in_chan,
  wafb_out_if.source    out_chan,
  wafb_cfg_if.sink      cfg_chan
);

  localparam int AW     = $clog2(MAX_BLOCK);
  localparam int NW     = $clog2(MAX_BLOCK + 1);
  localparam int A1     = NW + 1;
  localparam int SW     = wafb_pkg::SAMPLE_W;
  localparam int TW     = wafb_pkg::TAP_W;
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = SW + COEF_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int OW     = wafb_pkg::OUT_W;

  localparam logic [TW-1:0] TAP_LAST = TW'(wafb_pkg::TAP_COUNT - 1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  // Configuration registers.
  logic [wafb_pkg::BLEN_W-1:0] blen_r;
  logic [wafb_pkg::FSET_W-1:0] fset_r;

  // Sequencer state.
  wafb_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]    fill_r;
  logic [NW-1:0]    n_r;
  logic [wafb_pkg::FSET_W-1:0] set_r;
  logic [AW-1:0]    pos_r;
  logic [TW-1:0]    tap_r;
  logic [1:0]       cnt_r;

  // Sample buffer.
  logic signed [SW-1:0] mem [MAX_BLOCK];

  // Pipeline registers.
  logic                    s1_valid_r, s1_last_r;
  logic [TW-1:0]           s1_tap_r;
  logic signed [SW-1:0]    rd_r;
  logic                    s2_valid_r, s2_last_r;
  logic [TW-1:0]           s2_tap_r;
  logic signed [PROD_W-1:0] prod_lo_r, prod_hi_r;
  logic                    s3_valid_r, s3_last_r;
  logic signed [ACC_W-1:0] acc_lo_r, acc_hi_r;
  logic                    res_valid_r, res_last_r;
  logic [OW-1:0]           res_lo_r, res_hi_r;
  logic                    out_valid_r, out_last_r;
  logic [OW-1:0]           out_lo_r, out_hi_r;

  // Combinational signals.
  logic                 in_acc;
  logic                 cfg_acc;
  logic [NW-1:0]        n_eff;
  logic [NW:0]          fill_inc;
  logic                 blk_done;
  logic                 issue;
  logic                 tap0_issue;
  logic [AW:0]          pos_sum;
  logic                 pair_last;
  logic [A1-1:0]        addr_w;
  logic [AW-1:0]        rd_addr;
  logic signed [COEF_W-1:0] coef_lo, coef_hi;
  logic signed [ACC_W-1:0]  rnd_lo, rnd_hi;
  logic signed [ACC_W-1:0]  shr_lo, shr_hi;
  logic                 out_take;
  logic                 res_move;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;

  // Configuration port is always ready.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r <= wafb_pkg::BLEN_RESET;
      fset_r <= wafb_pkg::FSET_RESET;
    end else if (cfg_acc) begin
      if (cfg_chan.reg_index == wafb_pkg::REG_BLOCK_LENGTH) begin
        blen_r <= cfg_chan.wr_data[wafb_pkg::BLEN_W-1:0];
      end else if (cfg_chan.reg_index == wafb_pkg::REG_FILTER_SET) begin
        fset_r <= cfg_chan.wr_data[wafb_pkg::FSET_W-1:0];
      end
    end
  end

  // Effective block length, clamped to the supported range.
  always_comb begin
    if (blen_r < wafb_pkg::TAP_COUNT) begin
      n_eff = NW'(wafb_pkg::TAP_COUNT);
    end else if (blen_r > MAX_BLOCK) begin
      n_eff = NW'(MAX_BLOCK);
    end else begin
      n_eff = NW'(blen_r);
    end
  end

  assign fill_inc = {1'b0, fill_r} + (NW + 1)'(1);
  assign blk_done = in_acc && (fill_inc >= (NW + 1)'(n_eff));

  // Position and address of the current tap.
  assign pos_sum   = {1'b0, pos_r} + (AW + 1)'(2);
  assign pair_last = (pos_sum >= (AW + 1)'(n_r));

  always_comb begin
    if (pos_r >= AW'(tap_r)) begin
      addr_w = A1'(pos_r) - A1'(tap_r);
    end else begin
      addr_w = A1'(pos_r) + A1'(n_r) - A1'(tap_r);
    end
  end
  assign rd_addr = addr_w[AW-1:0];

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wafb_pkg::ST_IDLE: begin
        if (blk_done) begin
          state_nxt = wafb_pkg::ST_RUN;
        end
      end
      wafb_pkg::ST_RUN: begin
        if (issue && (tap_r == TAP_LAST) && pair_last) begin
          state_nxt = wafb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wafb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. A pair starts only while fewer than two older pairs
  // are still undelivered, so the output queue never overflows.
  always_comb begin
    in_chan.ready = 1'b0;
    issue         = 1'b0;
    case (state_r)
      wafb_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
      end
      wafb_pkg::ST_RUN: begin
        issue = (tap_r != '0) || (cnt_r < 2'd2);
      end
      default: begin
        in_chan.ready = 1'b0;
        issue         = 1'b0;
      end
    endcase
  end

  assign tap0_issue = issue && (tap_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wafb_pkg::ST_IDLE;
      fill_r  <= '0;
      n_r     <= NW'(wafb_pkg::TAP_COUNT);
      set_r   <= '0;
      pos_r   <= '0;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        fill_r <= blk_done ? '0 : fill_inc[NW-1:0];
      end
      if (blk_done) begin
        n_r   <= n_eff;
        set_r <= (fset_r >= wafb_pkg::FSET_W'(wafb_pkg::SET_COUNT)) ? '0 : fset_r;
        pos_r <= '0;
        tap_r <= '0;
      end else if (issue) begin
        if (tap_r == TAP_LAST) begin
          tap_r <= '0;
          pos_r <= pos_sum[AW-1:0];
        end else begin
          tap_r <= tap_r + TW'(1);
        end
      end
    end
  end

  // Sample buffer: written by incoming samples, read once per tap.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[fill_r[AW-1:0]] <= in_chan.sample;
    end
    if (issue) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Coefficient lookup for the tap in the multiply stage.
  assign coef_lo = COEF_W'(wafb_pkg::coef_round(
    wafb_pkg::COEF_Q30[set_r][wafb_pkg::BAND_LO][s1_tap_r], COEF_FRAC_BITS));
  assign coef_hi = COEF_W'(wafb_pkg::coef_round(
    wafb_pkg::COEF_Q30[set_r][wafb_pkg::BAND_HI][s1_tap_r], COEF_FRAC_BITS));

  // Stage control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r && (s2_tap_r == TAP_LAST);
    end
  end

  // Dual multiply and accumulate.
  always_ff @(posedge clk) begin
    s1_tap_r  <= tap_r;
    s1_last_r <= pair_last;
    s2_tap_r  <= s1_tap_r;
    s2_last_r <= s1_last_r;
    s3_last_r <= s2_last_r;
    prod_lo_r <= rd_r * coef_lo;
    prod_hi_r <= rd_r * coef_hi;
    if (s2_valid_r) begin
      if (s2_tap_r == '0) begin
        acc_lo_r <= ACC_W'(prod_lo_r);
        acc_hi_r <= ACC_W'(prod_hi_r);
      end else begin
        acc_lo_r <= acc_lo_r + ACC_W'(prod_lo_r);
        acc_hi_r <= acc_hi_r + ACC_W'(prod_hi_r);
      end
    end
  end

  // Round half away from zero: add half, less one for negative sums, then
  // shift arithmetically.
  assign rnd_lo = acc_lo_r + RND_HALF - $signed(ACC_W'(acc_lo_r[ACC_W-1]));
  assign rnd_hi = acc_hi_r + RND_HALF - $signed(ACC_W'(acc_hi_r[ACC_W-1]));
  assign shr_lo = rnd_lo >>> COEF_FRAC_BITS;
  assign shr_hi = rnd_hi >>> COEF_FRAC_BITS;

  // Two-entry output queue: a holding stage and the output register.
  assign out_take = out_valid_r && out_chan.ready;
  assign res_move = res_valid_r && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      res_valid_r <= s3_valid_r || (res_valid_r && !res_move);
      out_valid_r <= res_move || (out_valid_r && !out_chan.ready);
      cnt_r       <= cnt_r + 2'(tap0_issue) - 2'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      res_lo_r   <= shr_lo[OW-1:0];
      res_hi_r   <= shr_hi[OW-1:0];
      res_last_r <= s3_last_r;
    end
    if (res_move) begin
      out_lo_r   <= res_lo_r;
      out_hi_r   <= res_hi_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.low_band  = $signed(out_lo_r);
  assign out_chan.high_band = $signed(out_hi_r);
  assign out_chan.last      = out_last_r;

endmodule
`default_nettype wire

@@ sv/wafb_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Wavelet analysis filter bank checker
// Port-level checks of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module wafb_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [wafb_pkg::OUT_W-1:0]    out_low_band,
  input wire logic [wafb_pkg::OUT_W-1:0]    out_high_band,
  input wire logic                          out_last
);

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low_band)
      && $stable(out_high_band) && $stable(out_last))
    else $error("result request changed while stalled");

  // Input ready drops only after a sample request was taken.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped without an accepted sample");

  // A filter pass does not end as soon as input ready falls.
  a_pass_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |=> !in_ready)
    else $error("filter pass ended too early");

endmodule

bind wavelet_analysis_filter_bank_core wafb_checker u_wafb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_low_band  (out_chan.low_band),
  .out_high_band (out_chan.high_band),
  .out_last      (out_chan.last)
);
`default_nettype wire

@@ tb/sv/tb_wavelet_analysis_filter_bank_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Wavelet analysis filter bank core testbench
// Streams sample blocks into the core under changing block lengths and filter
// sets, predicts every lowpass/highpass pair with an independent circular
// convolution model, and checks the pairs in order with random back-pressure.
// ----------------------------------------------------------------------------
module tb_wavelet_analysis_filter_bank_core;
  import wafb_pkg::*;

  localparam int          MAXB          = MAX_BLOCK_DEF;
  localparam int          FRAC          = COEF_FRAC_DEF;
  localparam int          MIN_LEN       = TAP_COUNT;
  localparam int          ITEM_TARGET   = 220;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          TAIL_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Register indexes past the end of the register list; writes are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Filter set codes used by name in the directed part.
  localparam logic [CFG_DATA_W-1:0] FSET_FARRAS    = 8'd0;
  localparam logic [CFG_DATA_W-1:0] FSET_UNDEFINED = 8'hFF;

  // Filter taps with 30 fraction bits.
  localparam longint TAP_A = 747195449;
  localparam longint TAP_B = 94906266;
  localparam longint TAP_C = 12054676;
  localparam longint TAP_D = 816336241;
  localparam longint TAP_E = 630842971;
  localparam longint TAP_F = 251137819;
  localparam longint TAP_G = 122730666;
  localparam longint TAP_H = 94842993;
  localparam longint TAP_K = 37756886;

  typedef struct {
    logic signed [OUT_W-1:0] low_band;
    logic signed [OUT_W-1:0] high_band;
    logic                    last;
  } band_pair_t;

  // Divide by 2^sh with the magnitude rounded half away from zero.
  function automatic longint scale_down(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  // Block filter predictor: keeps its own copy of the registers and the
  // sample buffer, and queues the pairs each completed block produces.
  class band_pair_predictor;
    longint                  taps [SET_COUNT][2][TAP_COUNT];
    logic signed [SAMPLE_W-1:0] buffer [MAXB];
    int unsigned             blen_reg;
    int unsigned             fset_reg;
    int                      fill;
    band_pair_t              expected_pairs [$];
    int                      errors;
    int                      blocks;
    int                      checked;

    function new();
      longint q30 [SET_COUNT][2][TAP_COUNT];
      int s, b, t;
      q30 = '{
        '{ '{0, 0, -TAP_B, TAP_B, TAP_A, TAP_A, TAP_B, -TAP_B, TAP_C, TAP_C},
           '{-TAP_C, TAP_C, TAP_B, TAP_B, -TAP_A, TAP_A, -TAP_B, -TAP_B, 0, 0} },
        '{ '{0, -TAP_B, TAP_B, TAP_A, TAP_A, TAP_B, -TAP_B, TAP_C, TAP_C, 0},
           '{0, -TAP_C, TAP_C, TAP_B, TAP_B, -TAP_A, TAP_A, -TAP_B, -TAP_B, 0} },
        '{ '{TAP_C, TAP_C, -TAP_B, TAP_B, TAP_A, TAP_A, TAP_B, -TAP_B, 0, 0},
           '{0, 0, -TAP_B, -TAP_B, TAP_A, -TAP_A, TAP_B, TAP_B, TAP_C, -TAP_C} },
        '{ '{TAP_K, 0, -TAP_H, TAP_F, TAP_D, TAP_E, 0, -TAP_G, 0, 0},
           '{0, 0, -TAP_G, 0, TAP_E, -TAP_D, TAP_F, TAP_H, 0, -TAP_K} },
        '{ '{0, 0, -TAP_G, 0, TAP_E, TAP_D, TAP_F, -TAP_H, 0, TAP_K},
           '{-TAP_K, 0, TAP_H, TAP_F, -TAP_D, TAP_E, 0, -TAP_G, 0, 0} }
      };
      for (s = 0; s < SET_COUNT; s++)
        for (b = 0; b < 2; b++)
          for (t = 0; t < TAP_COUNT; t++)
            taps[s][b][t] = scale_down(q30[s][b][t], 30 - FRAC);
      blen_reg = 32'(BLEN_RESET);
      fset_reg = 32'(FSET_RESET);
      fill     = 0;
      errors   = 0;
      blocks   = 0;
      checked  = 0;
    endfunction

    // Effective block length after clamping to the supported range.
    function int active_length();
      if (blen_reg < MIN_LEN) return MIN_LEN;
      if (blen_reg > MAXB) return MAXB;
      return blen_reg;
    endfunction

    // Samples still needed before the current block is complete.
    function int samples_to_complete();
      return (active_length() > fill) ? active_length() - fill : 1;
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BLOCK_LENGTH: blen_reg = 32'(data);
        REG_FILTER_SET:   fset_reg = 32'(data[FSET_W-1:0]);
        default: ;
      endcase
    endfunction

    // Note an accepted sample; a completing sample queues the block's pairs.
    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      int         n, fs, i, j, idx;
      longint     acc_lo, acc_hi, r_lo, r_hi;
      band_pair_t p;
      n  = active_length();
      fs = (fset_reg < SET_COUNT) ? fset_reg : 0;
      if (fill < MAXB) buffer[fill] = s;
      fill++;
      if (fill < n) return;
      fill = 0;
      blocks++;
      for (i = 0; i < n; i += 2) begin
        acc_lo = 0;
        acc_hi = 0;
        for (j = 0; j < TAP_COUNT; j++) begin
          idx = (i >= j) ? i - j : i + n - j;
          acc_lo += taps[fs][BAND_LO][j] * longint'(buffer[idx]);
          acc_hi += taps[fs][BAND_HI][j] * longint'(buffer[idx]);
        end
        r_lo        = scale_down(acc_lo, FRAC);
        r_hi        = scale_down(acc_hi, FRAC);
        p.low_band  = r_lo[OUT_W-1:0];
        p.high_band = r_hi[OUT_W-1:0];
        p.last      = (i + 2 >= n);
        expected_pairs.push_back(p);
      end
    endfunction

    // Compare one delivered pair with the oldest expected pair.
    function void check_pair(logic signed [OUT_W-1:0] lo, logic signed [OUT_W-1:0] hi,
                             logic last);
      band_pair_t p;
      if (expected_pairs.size() == 0) begin
        $error("result pair with no expected pair waiting: low_band %0d high_band %0d",
               lo, hi);
        errors++;
        return;
      end
      p = expected_pairs.pop_front();
      checked++;
      if (lo !== p.low_band) begin
        $error("low_band mismatch: expected %0d, actual %0d", p.low_band, lo);
        errors++;
      end
      if (hi !== p.high_band) begin
        $error("high_band mismatch: expected %0d, actual %0d", p.high_band, hi);
        errors++;
      end
      if (last !== p.last) begin
        $error("last mismatch: expected %0b, actual %0b", p.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int          n_samples = 0;
  int          n_writes = 0;
  int          n_pauses = 0;
  bit          tx_steady = 1'b1;
  bit          rx_steady = 1'b1;
  int          rx_stall_left = 0;
  int          rx_gap;

  band_pair_predictor predictor = new();

  wafb_in_if  in_if();
  wafb_out_if out_if();
  wafb_cfg_if cfg_if();

  wavelet_analysis_filter_bank_core #(
    .MAX_BLOCK      (MAXB),
    .COEF_FRAC_BITS (FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wavelet_analysis_filter_bank_core verification failed");
      $finish;
    end
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Result receiver back-pressure.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_if.ready  <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      rx_gap = rx_steady ? 0 : idle_len();
      out_if.ready  <= (rx_gap == 0);
      rx_stall_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      predictor.check_pair(out_if.low_band, out_if.high_band, out_if.last);
  end

  // Send one sample request after an idle gap of the given length.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    predictor.take_sample(s);
    n_samples++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic send_run(input int count);
    repeat (count) push_sample(pick_sample(), tx_steady ? 0 : idle_len());
  endtask

  task automatic drain();
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  // Wait until the core has delivered everything and gone quiet.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk); while (!cfg_if.ready);
    predictor.write_reg(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    logic signed [SAMPLE_W-1:0] corner_samples [10];
    int  phase_no, kind, n_eff, blocks, b, k;
    bit  big_done;

    in_if.valid      = 1'b0;
    in_if.sample     = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wr_data   = '0;
    out_if.ready     = 1'b0;
    rst_n            = 1'b0;
    corner_samples = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000,
                       16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Shortest block, Farras set, extreme samples back to back.
    write_reg(REG_BLOCK_LENGTH, 8'd10);
    write_reg(REG_FILTER_SET, FSET_FARRAS);
    foreach (corner_samples[i]) push_sample(corner_samples[i], 0);
    hold_input();
    settle();

    // Length below range and an undefined filter set both fall back; writes
    // past the register list are dropped.
    write_reg(REG_BLOCK_LENGTH, 8'd0);
    write_reg(REG_FILTER_SET, FSET_UNDEFINED);
    write_reg(REG_SPARE_2, 8'h55);
    write_reg(REG_SPARE_3, 8'hAA);
    rx_steady = 1'b0;
    for (int i = 0; i < 10; i++)
      push_sample(i[0] ? 16'sh8000 : 16'sh7FFF, idle_len());
    hold_input();

    // Random phases: mostly short blocks, one block at the largest size.
    phase_no = 0;
    big_done = 1'b0;
    while (n_samples < ITEM_TARGET) begin
      settle();
      kind = $urandom_range(0, 5);
      if (!big_done && n_samples >= 60) begin
        write_reg(REG_BLOCK_LENGTH, 8'hFF);
        big_done = 1'b1;
        kind     = 2;
      end else begin
        write_reg(REG_BLOCK_LENGTH, 8'($urandom_range(0, 26)));
      end
      write_reg(REG_FILTER_SET, 8'($urandom_range(0, 255)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      n_eff = predictor.active_length();

      if (kind == 0 && phase_no != 0) begin
        // Shorten the length while a block is partly filled.
        k = $urandom_range(1, n_eff - 1);
        send_run(k);
        hold_input();
        settle();
        write_reg(REG_BLOCK_LENGTH, 8'($urandom_range(0, n_eff - 1)));
        send_run(predictor.samples_to_complete());
        send_run(predictor.samples_to_complete());
      end else begin
        blocks = (n_eff == MAXB) ? 1 : $urandom_range(1, 3);
        if (phase_no == 0) blocks = 2;
        for (b = 0; b < blocks; b++) begin
          send_run(predictor.samples_to_complete());
          // Hold the sender until the block's pairs have all arrived.
          if (b == 0 && blocks > 1 && (kind == 1 || phase_no == 0)) begin
            hold_input();
            drain();
            n_pauses++;
          end
        end
      end
      hold_input();
      phase_no++;
    end

    // A trailing partial block produces nothing.
    send_run($urandom_range(1, predictor.samples_to_complete() - 1));
    hold_input();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predictor.pending() != 0) begin
      $error("%0d expected pairs never arrived", predictor.pending());
      predictor.errors++;
    end

    $display("Sent %0d samples over %0d random phases; %0d blocks completed.",
             n_samples, phase_no, predictor.blocks);
    $display("Checked %0d result pairs, %0d register writes, %0d drain pauses.",
             predictor.checked, n_writes, n_pauses);
    if (predictor.errors == 0) begin
      $display("wavelet_analysis_filter_bank_core verification clean");
    end else begin
      $display("wavelet_analysis_filter_bank_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
